FILE: rtl/mora_pkg.sv
// ----------------------------------------------------------------------------
// mora_pkg: shared types and constants of the maximal ones rectangle block
// Holds the fixed field widths, the area ceiling, the flags that travel with
// each classified pixel and the state encoding of the execution engine.
// ----------------------------------------------------------------------------
package mora_pkg;

  // Width and reset value of the row width register.
  localparam int          CFG_W     = 11;
  localparam logic [10:0] CFG_RESET = 11'd1024;

  // Width and ceiling of the reported area.
  localparam int          AREA_W   = 21;
  localparam logic [20:0] AREA_MAX = 21'h1F_FFFF;

  // Flags attached to one classified pixel.
  typedef struct packed {
    logic pixel;
    logic frame_last;
    logic row_end;
  } item_flags_t;

  // Execution engine states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC,
    ST_CHECK,
    ST_POP,
    ST_RESULT
  } back_state_t;

endpackage

FILE: rtl/mora_ram.sv
// ----------------------------------------------------------------------------
// mora_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mora_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mora_fifo.sv
// ----------------------------------------------------------------------------
// mora_fifo: small first-in first-out queue in flip-flops
// Shows the oldest entry while not empty; DEPTH must be at least two.
// ----------------------------------------------------------------------------
module mora_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTRW-1:0]  wptr;
  logic [PTRW-1:0]  rptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

FILE: rtl/mora_front.sv
// ----------------------------------------------------------------------------
// mora_front: pixel intake and row classification
// Holds the row width register and the column counter, tags every accepted
// pixel with its column and a row end flag, and passes it to the item queue.
// ----------------------------------------------------------------------------
module mora_front #(
  parameter int MAX_COLS = 1024,
  parameter int IW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [10:0]           cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  pixel,
  input  logic                  frame_last,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  q_push,
  output mora_pkg::item_flags_t q_flags,
  output logic [IW-1:0]         q_col
);

  import mora_pkg::*;

  localparam int PW = $clog2(MAX_COLS + 1);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  logic [CFG_W-1:0] cols_in_use;
  logic [IW-1:0]    col_pos;
  logic [CW-1:0]    cols_ext;
  logic [CW-1:0]    width_eff;
  logic [CW-1:0]    next_col;
  logic             row_end;
  logic             accept;

  assign cfg_ready = 1'b1;

  // Row width clamped to the range the column store supports.
  assign cols_ext  = CW'(cols_in_use);
  assign width_eff = (cols_ext == '0) ? CW'(1) :
                     (cols_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_ext;

  // A row ends at the frame end or at the last column of the width.
  assign next_col = CW'(col_pos) + CW'(1);
  assign row_end  = frame_last || (next_col >= width_eff);

  assign full    = q_full || clearing;
  assign accept  = push && !full;
  assign q_push  = accept;
  assign q_flags = '{pixel: pixel, frame_last: frame_last, row_end: row_end};
  assign q_col   = col_pos;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cols_in_use <= cfg_data;
    end
  end

  // Column counter, restarted at every row end.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
    end else if (accept) begin
      col_pos <= row_end ? '0 : next_col[IW-1:0];
    end
  end

endmodule

FILE: rtl/mora_back.sv
// ----------------------------------------------------------------------------
// mora_back: histogram and monotonic stack engine
// Updates the column heights, pops taller stacked columns while scoring their
// areas, flushes the stack at each row end, reports the best area at the
// frame end and then sweeps the height store back to zero.
// ----------------------------------------------------------------------------
module mora_back #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int IW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  mora_pkg::item_flags_t q_flags,
  input  logic [IW-1:0]         q_col,
  output logic                  clearing,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [20:0]           res_area
);

  import mora_pkg::*;

  localparam int PW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int SW    = IW + HW;
  localparam int PRODW = HW + PW;
  localparam int EW    = (PRODW > AREA_W) ? PRODW : AREA_W;

  back_state_t state;
  back_state_t state_next;

  // Current item.
  item_flags_t it_flags;
  logic [IW-1:0] it_col;

  // Height store ports.
  logic          hram_we;
  logic [IW-1:0] hram_waddr;
  logic [HW-1:0] hram_wdata;
  logic [HW-1:0] hram_rdata;

  // Stack store ports; the top entry lives in registers.
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [IW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;
  logic [IW-1:0] tos_idx;
  logic [HW-1:0] tos_h;
  logic [PW-1:0] depth;
  logic [PW-1:0] depth_m1;
  logic [PW-1:0] depth_m2;

  // Working values of the pop loop.
  logic [HW-1:0] cur_h;
  logic [PW-1:0] cur_pos;
  logic          flushing;
  logic [HW-1:0] h_new;
  logic [HW-1:0] eff_h;
  logic [PW-1:0] eff_pos;
  logic          eff_flush;
  logic [PW-1:0] pop_w;

  // Area scoring.
  logic [PRODW-1:0]  prod;
  logic              prod_valid;
  logic [EW-1:0]     prod_ext;
  logic [AREA_W-1:0] area_sat;
  logic [AREA_W-1:0] best;

  // Clearing sweep.
  logic [IW-1:0] clr_addr;
  logic          clr_last;

  // Control strobes.
  logic start_pop;
  logic do_push;
  logic flush_begin;
  logic flush_done;

  mora_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_height_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .raddr (q_col),
    .rdata (hram_rdata)
  );

  mora_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata ({tos_idx, tos_h}),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign clearing = (state == ST_CLEAR);
  assign res_area = best;
  assign clr_last = (clr_addr == IW'(MAX_COLS - 1));

  // Stack addresses below the register-held top entry.
  assign depth_m1  = depth - PW'(1);
  assign depth_m2  = depth - PW'(2);
  assign stk_waddr = depth_m1[IW-1:0];
  assign stk_raddr = depth_m2[IW-1:0];

  // New height of the current column, saturating at the row limit.
  assign h_new = !it_flags.pixel ? '0 :
                 (hram_rdata < HW'(MAX_ROWS)) ? hram_rdata + 1'b1 : hram_rdata;

  // The first decision of an item uses the fresh height; later ones use
  // the values held across the pop loop.
  assign eff_h     = (state == ST_EXEC) ? h_new : cur_h;
  assign eff_pos   = (state == ST_EXEC) ? PW'(it_col) : cur_pos;
  assign eff_flush = (state == ST_EXEC) ? 1'b0 : flushing;

  // Width over which the popped column was the shortest bar.
  assign pop_w = (depth >= PW'(2)) ?
                 cur_pos - PW'(stk_rdata[SW-1:HW]) - PW'(1) : cur_pos;

  // Saturated area of the last product.
  assign prod_ext = EW'(prod);
  assign area_sat = (prod_ext > EW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    hram_we     = 1'b0;
    hram_waddr  = it_col;
    hram_wdata  = h_new;
    res_push    = 1'b0;
    start_pop   = 1'b0;
    do_push     = 1'b0;
    flush_begin = 1'b0;
    flush_done  = 1'b0;
    case (state)
      ST_CLEAR: begin
        hram_we    = 1'b1;
        hram_waddr = clr_addr;
        hram_wdata = '0;
        if (clr_last) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC, ST_CHECK: begin
        hram_we = (state == ST_EXEC);
        if ((depth != '0) && (tos_h > eff_h)) begin
          start_pop  = 1'b1;
          state_next = ST_POP;
        end else if (!eff_flush) begin
          do_push = 1'b1;
          if (it_flags.row_end) begin
            flush_begin = 1'b1;
            state_next  = ST_CHECK;
          end else begin
            state_next = ST_FETCH;
          end
        end else begin
          flush_done = 1'b1;
          state_next = it_flags.frame_last ? ST_RESULT : ST_FETCH;
        end
      end
      ST_POP: begin
        state_next = ST_CHECK;
      end
      ST_RESULT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign stk_we = do_push && (depth != '0);

  // Control registers: stack depth, flush flag, best area and sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      flushing   <= 1'b0;
      prod_valid <= 1'b0;
      best       <= '0;
      clr_addr   <= '0;
    end else begin
      prod_valid <= (state == ST_POP);
      if (prod_valid && (area_sat > best)) begin
        best <= area_sat;
      end
      if (do_push) begin
        depth <= depth + 1'b1;
      end
      if (state == ST_POP) begin
        depth <= depth_m1;
      end
      if (flush_begin) begin
        flushing <= 1'b1;
      end
      if (flush_done) begin
        flushing <= 1'b0;
        depth    <= '0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        depth    <= '0;
        flushing <= 1'b0;
        best     <= '0;
      end
    end
  end

  // Payload registers of the current item and the pop loop.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_flags <= q_flags;
      it_col   <= q_col;
    end
    if (start_pop) begin
      cur_h   <= eff_h;
      cur_pos <= eff_pos;
    end
    if (flush_begin) begin
      cur_h   <= '0;
      cur_pos <= PW'(it_col) + PW'(1);
    end
    if (do_push) begin
      tos_idx <= eff_pos[IW-1:0];
      tos_h   <= eff_h;
    end
    if (state == ST_POP) begin
      prod    <= PRODW'(tos_h) * PRODW'(pop_w);
      tos_idx <= stk_rdata[SW-1:HW];
      tos_h   <= stk_rdata[HW-1:0];
    end
  end

endmodule

FILE: rtl/maximal_ones_rectangle_area_unit.sv
// The engine fetches a pixel, updates its height and pops each taller stacked column
// in a pop and a check step before pushing it; a row end then flushes the stack likewise.
// A new pixel is fetched only once the last is done; the item queue buffers the intake.
// At a frame end the result is reported, then the height store is swept to zero.
// Reset (rst, synchronous) starts the same sweep; full stays high meanwhile.
// ----------------------------------------------------------------------------
// maximal_ones_rectangle_area_unit: largest all-ones rectangle of a binary image
// Pixels arrive in raster order; the intake tags them and queues them for the
// histogram engine, which reports the best area through a result queue.
// ----------------------------------------------------------------------------
module maximal_ones_rectangle_area_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        pixel,
  input  logic        frame_last,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] max_area
);

  import mora_pkg::*;

  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FW = $bits(item_flags_t);
  localparam int QW = FW + IW;

  logic          clearing;
  logic          fq_push;
  logic          fq_full;
  item_flags_t   fq_flags;
  logic [IW-1:0] fq_col;
  logic [QW-1:0] bq_data;
  logic          bq_empty;
  logic          bq_pop;
  logic          res_push;
  logic          res_full;
  logic [20:0]   res_area;

  mora_front #(.MAX_COLS(MAX_COLS), .IW(IW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .pixel      (pixel),
    .frame_last (frame_last),
    .clearing   (clearing),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_flags    (fq_flags),
    .q_col      (fq_col)
  );

  // Item queue between intake and engine.
  mora_fifo #(.WIDTH(QW), .DEPTH(4)) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata ({fq_flags, fq_col}),
    .full  (fq_full),
    .pop   (bq_pop),
    .rdata (bq_data),
    .empty (bq_empty)
  );

  mora_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .IW(IW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (bq_empty),
    .q_pop    (bq_pop),
    .q_flags  (item_flags_t'(bq_data[QW-1:IW])),
    .q_col    (bq_data[IW-1:0]),
    .clearing (clearing),
    .res_full (res_full),
    .res_push (res_push),
    .res_area (res_area)
  );

  // Result queue towards the consumer.
  mora_fifo #(.WIDTH(AREA_W), .DEPTH(2)) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_area),
    .full  (res_full),
    .pop   (pop),
    .rdata (max_area),
    .empty (empty)
  );

endmodule

FILE: rtl/mora_checker.sv
// ----------------------------------------------------------------------------
// mora_checker: port-level checks of the maximal ones rectangle block
// Tracks frames accepted against results taken and checks the result ports.
// ----------------------------------------------------------------------------
module mora_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        frame_last,
  input logic        empty,
  input logic        pop,
  input logic [20:0] max_area
);

  localparam longint AreaProd  = longint'(MAX_COLS) * longint'(MAX_ROWS);
  localparam longint AreaBound = (AreaProd > 64'h1F_FFFF) ? 64'h1F_FFFF : AreaProd;

  logic [3:0] frames_pending;
  logic       frame_in;
  logic       result_out;

  assign frame_in   = push && !full && frame_last;
  assign result_out = pop && !empty;

  // Frames whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_pending <= '0;
    end else if (frame_in && !result_out) begin
      frames_pending <= frames_pending + 1'b1;
    end else if (result_out && !frame_in) begin
      frames_pending <= frames_pending - 1'b1;
    end
  end

  // Reset starts the clearing sweep with nothing to report.
  a_reset_state: assert property (@(posedge clk) rst |=> full && empty)
    else $error("block not blocked and empty after reset");

  // A result is only offered for a frame that has been accepted.
  a_result_has_frame: assert property (@(posedge clk) disable iff (rst)
    !empty |-> frames_pending != 4'd0)
    else $error("result offered without an accepted frame");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(max_area))
    else $error("stalled result changed");

  // No area can exceed the full image.
  a_area_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> max_area <= 21'(AreaBound))
    else $error("area larger than the image");

endmodule

bind maximal_ones_rectangle_area_unit mora_checker #(
  .MAX_COLS(MAX_COLS),
  .MAX_ROWS(MAX_ROWS)
) u_mora_checker (.*);
